// ----- design/sips_pkg.sv -----
// ----------------------------------------------------------------------------
// sips_pkg
// Shared types and constants for the sorted insert position search block.
// ----------------------------------------------------------------------------
`default_nettype none

package sips_pkg;

    localparam int MODE_W      = 2;
    localparam int POS_W       = 11;
    localparam int OUT_TDATA_W = 16;

    typedef logic [MODE_W-1:0] t_mode;

    localparam t_mode MODE_LOAD  = 2'd0;
    localparam t_mode MODE_QUERY = 2'd1;
    localparam t_mode MODE_CLEAR = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

endpackage

`default_nettype wire

// ----- design/sorted_insert_position_search.sv -----
// ----------------------------------------------------------------------------
// sorted_insert_position_search
// Ascending table of signed values with a lower-bound insert position search.
// ----------------------------------------------------------------------------
// Input stream: tuser carries the mode (load, query, clear), tdata the value.
// Load appends the value at the current count and returns that index; a load
// into a full table is dropped and returns the count with status set. Clear
// empties the table and returns zero. Query returns the first index whose
// entry is not less than the target, or the count when there is none.
// One result per input transfer, in order, on the output stream.
// Load, clear and unused modes pass through ST_FINISH into the output register.
// A query first makes P probes in ST_PROBE, then passes ST_FINISH; P is at most
// ceil(log2(count + 1)) (11 for a full 1024-entry table). Each probe is one
// synchronous table read whose data the next cycle compares and uses to
// select the following probe address, so the table read port paces a query.
// One item is in work at a time; the next is taken once its result sits in
// the output register, which holds it while the receiver stalls. A result
// that finds the output still full waits, and input stays blocked meanwhile.
// Reset empties the table (count to zero) at once; no memory sweep is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_insert_position_search #(
    parameter int TABLE_DEPTH = 1024,
    parameter int DATA_WIDTH  = 32
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [DATA_WIDTH-1:0] value, rest zero pad
    input  wire [((DATA_WIDTH+7)/8)*8-1:0]       i_s_axis_tdata,
    // [1:0] mode
    input  wire [sips_pkg::MODE_W-1:0]           i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  wire                                  i_m_axis_tready,
    // [10:0] position, rest zero pad
    output logic [sips_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // [0] status
    output logic [0:0]                           o_m_axis_tuser
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int EXT_W = CNT_W + sips_pkg::POS_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PROBE  = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]                 r_state, n_state;
    logic [CNT_W-1:0]           r_count, n_count;
    logic [CNT_W-1:0]           r_lo, n_lo;
    logic [CNT_W-1:0]           r_hi, n_hi;
    logic [CNT_W-1:0]           r_mid, n_mid;
    logic [DATA_WIDTH-1:0]      r_target, n_target;
    logic [CNT_W-1:0]           r_res_pos, n_res_pos;
    logic                       r_res_status, n_res_status;
    logic                       r_out_valid, n_out_valid;
    logic [sips_pkg::POS_W-1:0] r_out_pos, n_out_pos;
    logic                       r_out_status, n_out_status;

    logic                       w_in_xfer;
    logic                       w_we;
    logic [DATA_WIDTH-1:0]      w_rdata;
    logic [DATA_WIDTH-1:0]      w_in_value;
    logic                       w_less;
    logic [CNT_W-1:0]           w_lo_inc;
    logic [CNT_W-1:0]           w_mid_l;
    logic [CNT_W-1:0]           w_mid_e;
    logic [EXT_W-1:0]           w_pos_ext;

    assign w_in_value = i_s_axis_tdata[DATA_WIDTH-1:0];
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_xfer = i_s_axis_tvalid && o_s_axis_tready;

    assign w_less   = $signed(w_rdata) < $signed(r_target);
    assign w_lo_inc = r_mid + CNT_W'(1);
    assign w_mid_l  = w_lo_inc + ((r_hi - w_lo_inc) >> 1);
    assign w_mid_e  = r_lo + ((r_mid - r_lo) >> 1);

    assign w_pos_ext = {{sips_pkg::POS_W{1'b0}}, r_res_pos};

    sips_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_in_value),
        .i_raddr (n_mid[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_target     = r_target;
        n_res_pos    = r_res_pos;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_pos    = r_out_pos;
        n_out_status = r_out_status;
        w_we         = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_res_pos    = '0;
                    n_res_status = sips_pkg::STATUS_OK;
                    n_state      = ST_FINISH;
                    case (i_s_axis_tuser)
                        sips_pkg::MODE_LOAD: begin
                            n_res_pos = r_count;
                            if (r_count < CNT_W'(TABLE_DEPTH)) begin
                                w_we    = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end else begin
                                n_res_status = sips_pkg::STATUS_FULL;
                            end
                        end
                        sips_pkg::MODE_QUERY: begin
                            n_target = w_in_value;
                            n_lo     = '0;
                            n_hi     = r_count;
                            n_mid    = r_count >> 1;
                            if (r_count != '0) begin
                                n_state = ST_PROBE;
                            end
                        end
                        sips_pkg::MODE_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PROBE: begin
                if (w_less) begin
                    n_lo = w_lo_inc;
                    if (w_lo_inc < r_hi) begin
                        n_mid = w_mid_l;
                    end else begin
                        n_res_pos = w_lo_inc;
                        n_state   = ST_FINISH;
                    end
                end else begin
                    n_hi = r_mid;
                    if (r_lo < r_mid) begin
                        n_mid = w_mid_e;
                    end else begin
                        n_res_pos = r_lo;
                        n_state   = ST_FINISH;
                    end
                end
                n_res_status = sips_pkg::STATUS_OK;
            end
            ST_FINISH: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_pos    = w_pos_ext[sips_pkg::POS_W-1:0];
                    n_out_status = r_res_status;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_target     <= n_target;
        r_res_pos    <= n_res_pos;
        r_res_status <= n_res_status;
        r_out_pos    <= n_out_pos;
        r_out_status <= n_out_status;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(sips_pkg::OUT_TDATA_W - sips_pkg::POS_W){1'b0}}, r_out_pos};
    assign o_m_axis_tuser  = r_out_status;

endmodule

`default_nettype wire

// ----- design/sips_ram.sv -----
// ----------------------------------------------------------------------------
// sips_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sips_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- design/sips_checker.sv -----
// ----------------------------------------------------------------------------
// sips_checker
// Port-level checks for the sorted insert position search block.
// ----------------------------------------------------------------------------
`default_nettype none

module sips_checker #(
    parameter int TABLE_DEPTH = 1024
) (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_s_axis_tvalid,
    input wire                              o_s_axis_tready,
    input wire                              o_m_axis_tvalid,
    input wire                              i_m_axis_tready,
    input wire [sips_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input wire [0:0]                        o_m_axis_tuser
);

    // a held result must not change under backpressure
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output changed while stalled");

    // one item in work at a time
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken while an item is in work");

    // a dropped load reports the full count
    a_full_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser[0] == sips_pkg::STATUS_FULL) |->
            o_m_axis_tdata[sips_pkg::POS_W-1:0] == sips_pkg::POS_W'(TABLE_DEPTH))
        else $error("full status with wrong position");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind sorted_insert_position_search sips_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_sips_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

// ----- tb/sips_checker.sv -----
// ----------------------------------------------------------------------------
// sips_scoreboard
// Watches both streams of the insert position search block, keeps its own
// copy of the table and entry count, works out the position and status each
// accepted input transfer should return, and compares every output transfer
// in order with the oldest outstanding result.
// ----------------------------------------------------------------------------

module sips_scoreboard (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_tvalid,
    input  wire                                 i_s_tready,
    input  wire [31:0]                          i_s_tdata,    // [31:0] value
    input  wire [sips_pkg::MODE_W-1:0]          i_s_tuser,    // [1:0] mode
    input  wire                                 i_m_tvalid,
    input  wire                                 i_m_tready,
    input  wire [sips_pkg::OUT_TDATA_W-1:0]     i_m_tdata,    // [10:0] position, rest zero
    input  wire [0:0]                           i_m_tuser,    // [0] status
    output int                                  o_fail_count,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 1024;
    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [sips_pkg::POS_W-1:0] position;
        logic                       status;
    } t_result;

    logic signed [31:0] entry_mem [TABLE_DEPTH];
    int unsigned        entry_count;
    t_result            expected_results[$];
    t_result            oldest;
    int                 fail_count;
    int                 results_seen;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t ns: result %0d %s mismatch: got %0h, want %0h",
                     $realtime, results_seen, what, got, want);
    endtask

    function automatic logic [sips_pkg::POS_W-1:0] lower_bound_pos(
        logic signed [31:0] target);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = entry_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (entry_mem[mid] < target)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo[sips_pkg::POS_W-1:0];
    endfunction

    function automatic t_result apply_item(sips_pkg::t_mode mode,
                                           logic signed [31:0] value);
        t_result r;
        r.position = '0;
        r.status   = sips_pkg::STATUS_OK;
        case (mode)
            sips_pkg::MODE_LOAD: begin
                r.position = entry_count[sips_pkg::POS_W-1:0];
                if (entry_count < TABLE_DEPTH) begin
                    entry_mem[entry_count] = value;
                    entry_count++;
                end else begin
                    r.status = sips_pkg::STATUS_FULL;
                end
            end
            sips_pkg::MODE_QUERY: r.position = lower_bound_pos(value);
            sips_pkg::MODE_CLEAR: entry_count = 0;
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            entry_count = 0;
            expected_results.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                expected_results = {expected_results,
                                    apply_item(sips_pkg::t_mode'(i_s_tuser), i_s_tdata)};
            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transfer", 32'(i_m_tdata), '0);
                end else begin
                    oldest = expected_results.pop_front();
                    if (i_m_tdata[sips_pkg::POS_W-1:0] !== oldest.position)
                        report_mismatch("position", 32'(i_m_tdata[sips_pkg::POS_W-1:0]),
                                        32'(oldest.position));
                    if (i_m_tdata[sips_pkg::OUT_TDATA_W-1:sips_pkg::POS_W] !== '0)
                        report_mismatch("tdata pad",
                            32'(i_m_tdata[sips_pkg::OUT_TDATA_W-1:sips_pkg::POS_W]), '0);
                    if (i_m_tuser[0] !== oldest.status)
                        report_mismatch("status", 32'(i_m_tuser[0]), 32'(oldest.status));
                end
                results_seen++;
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_results.size();
    end

endmodule

// ----- tb/sorted_insert_position_search_tb.sv -----
// ----------------------------------------------------------------------------
// sorted_insert_position_search_tb
// Drives load, query, clear and unused-mode transfers into the block: a short
// directed pass over the value extremes, empty and full tables, duplicates
// and unsorted loads, then mostly ascending load runs followed by queries
// aimed at and around loaded values, with random gaps and stalls on both
// sides, long receiver hold-offs and one full 1024-entry table.
// ----------------------------------------------------------------------------

module sorted_insert_position_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int              TABLE_DEPTH  = 1024;
    localparam int              TOTAL_ITEMS  = 1750;
    localparam int              CYCLE_LIMIT  = 500000;
    localparam int              DRAIN_CYCLES = 20;
    localparam sips_pkg::t_mode MODE_UNUSED  = 2'd3;

    logic            clk      = 1'b0;
    logic            rst_n    = 1'b0;
    logic            s_tvalid = 1'b0;
    logic [31:0]     s_tdata  = '0;
    sips_pkg::t_mode s_tuser  = sips_pkg::MODE_LOAD;
    logic            m_tready = 1'b0;

    wire                             s_tready;
    wire                             m_tvalid;
    wire [sips_pkg::OUT_TDATA_W-1:0] m_tdata;
    wire [0:0]                       m_tuser;

    int fail_count;
    int pending_count;
    int cycle_count = 0;
    int items_sent  = 0;
    int rx_hold     = 0;
    bit tx_steady   = 1'b0;
    bit rx_steady   = 1'b0;

    logic signed [31:0] loaded[$];

    sorted_insert_position_search dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    sips_scoreboard checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sorted_insert_position_search test failed");
            $finish;
        end
    end

    // receiver: random stall per result, or a long hold-off when requested
    initial begin
        int gap;
        wait (rst_n);
        forever begin
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end else begin
                gap = rx_steady ? 0 : $urandom_range(0, 7);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    task automatic send_item(sips_pkg::t_mode mode, logic [31:0] value);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= mode;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
        if (mode == sips_pkg::MODE_LOAD && loaded.size() < TABLE_DEPTH)
            loaded = {loaded, value};
        if (mode == sips_pkg::MODE_CLEAR)
            loaded.delete();
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
    endtask

    // non-decreasing values continuing from the last loaded entry
    task automatic load_run(int n, int unsigned step_max, bit from_min);
        longint acc;
        if (loaded.size() > 0)
            acc = longint'(loaded[$]);
        else if (from_min)
            acc = -64'sd2147483648;
        else
            acc = longint'($signed($urandom()));
        repeat (n) begin
            if (loaded.size() > 0) begin
                if ($urandom_range(0, 4) != 0)
                    acc = acc + $urandom_range(1, step_max);
                if (acc > 64'sd2147483647)
                    acc = 64'sd2147483647;
            end
            send_item(sips_pkg::MODE_LOAD, acc[31:0]);
        end
    endtask

    function automatic logic [31:0] pick_target();
        logic [31:0] t;
        int          sel;
        sel = $urandom_range(0, 9);
        if (loaded.size() == 0 || sel < 2)
            t = $urandom();
        else if (sel == 2)
            t = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else begin
            t = loaded[$urandom_range(0, loaded.size() - 1)];
            if (sel >= 7)
                t = t + ($urandom_range(0, 1) ? 32'h0000_0001 : 32'hFFFF_FFFF);
        end
        return t;
    endfunction

    initial begin
        logic [31:0] edge_targets[8];
        int          n;
        int          phase;

        edge_targets = '{32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF, 32'h0000_0000,
                         32'h0000_0001, 32'h0000_0002, 32'h7FFF_FFFE, 32'h7FFF_FFFF};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, extremes, duplicates, unused mode, clear, unsorted loads
        send_item(sips_pkg::MODE_QUERY, 32'h0000_0000);
        send_item(sips_pkg::MODE_QUERY, 32'h8000_0000);
        send_item(sips_pkg::MODE_LOAD, 32'h8000_0000);
        send_item(sips_pkg::MODE_LOAD, 32'hFFFF_FFFF);
        send_item(sips_pkg::MODE_LOAD, 32'h0000_0000);
        send_item(sips_pkg::MODE_LOAD, 32'h0000_0000);
        send_item(sips_pkg::MODE_LOAD, 32'h0000_0001);
        send_item(sips_pkg::MODE_LOAD, 32'h7FFF_FFFF);
        foreach (edge_targets[i])
            send_item(sips_pkg::MODE_QUERY, edge_targets[i]);
        send_item(MODE_UNUSED, 32'hFFFF_FFFF);
        send_item(sips_pkg::MODE_QUERY, 32'h5555_5555);
        send_item(sips_pkg::MODE_CLEAR, 32'hAAAA_AAAA);
        send_item(sips_pkg::MODE_QUERY, 32'h7FFF_FFFF);
        send_item(sips_pkg::MODE_LOAD, 32'd10);
        send_item(sips_pkg::MODE_LOAD, 32'hFFFF_FFF6);
        send_item(sips_pkg::MODE_LOAD, 32'd3);
        send_item(sips_pkg::MODE_QUERY, 32'd0);
        send_item(sips_pkg::MODE_QUERY, 32'd5);

        // receiver holds off while the sender keeps offering
        wait_drained();
        rx_hold   = 400;
        tx_steady = 1'b1;
        repeat (20) send_item(sips_pkg::MODE_QUERY, pick_target());
        tx_steady = 1'b0;
        wait_drained();

        // full table, overflowing loads, deepest searches
        send_item(sips_pkg::MODE_CLEAR, $urandom());
        load_run(TABLE_DEPTH, 32'd1 << 22, 1'b1);
        send_item(sips_pkg::MODE_LOAD, $urandom());
        send_item(sips_pkg::MODE_LOAD, 32'h7FFF_FFFF);
        rx_hold = 300;
        repeat (30) send_item(sips_pkg::MODE_QUERY, pick_target());
        send_item(sips_pkg::MODE_QUERY, 32'h7FFF_FFFF);
        send_item(sips_pkg::MODE_QUERY, 32'h8000_0000);
        wait_drained();

        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            phase++;
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0)
                send_item(sips_pkg::MODE_CLEAR, $urandom());
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 30);
            if ($urandom_range(0, 9) == 0)
                repeat (n) send_item(sips_pkg::MODE_LOAD, $urandom());
            else
                load_run(n, 32'd1 << $urandom_range(0, 28), $urandom_range(0, 5) == 0);
            repeat ($urandom_range(4, 24)) begin
                case ($urandom_range(0, 19))
                    0:       send_item(MODE_UNUSED, $urandom());
                    1:       load_run(1, 32'd1 << $urandom_range(0, 28), 1'b0);
                    default: send_item(sips_pkg::MODE_QUERY, pick_target());
                endcase
            end
            if (phase % 4 == 0)
                wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("sorted_insert_position_search test passed");
        else
            $display("sorted_insert_position_search test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
design/sips_pkg.sv
design/sips_ram.sv
design/sorted_insert_position_search.sv
design/sips_checker.sv
tb/sips_checker.sv
tb/sorted_insert_position_search_tb.sv
